// File: sv/dlsp_pkg.sv
// ----------------------------------------------------------------------------
// dlsp_pkg
// Shared types and constants of the depth to laser scan projector.
// ----------------------------------------------------------------------------
package dlsp_pkg;

  localparam logic [16:0]        FAR_RANGE  = 17'd100000;
  localparam logic signed [17:0] PITCH_C    = 18'sd30794;
  localparam logic signed [17:0] PITCH_S    = 18'sd11202;
  localparam logic signed [25:0] Z_90       = 26'sd5898240;
  localparam logic [35:0]        SQ_MAX     = 36'd10000000000;

  localparam logic [21:0] ATAN_TAB [16] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115
  };

  localparam logic [4:0] DIV_LAST  = 5'd31;
  localparam logic [4:0] ISQ_LAST  = 5'd17;
  localparam logic [4:0] CORD_LAST = 5'd15;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_READ  = 1'b1;
  localparam logic RK_BIN     = 1'b0;
  localparam logic RK_FRAME   = 1'b1;

  typedef enum logic [2:0] {
    CFG_FOCAL_BASELINE = 3'd0,
    CFG_FOCAL_X        = 3'd1,
    CFG_FOCAL_Y        = 3'd2,
    CFG_CENTER_X       = 3'd3,
    CFG_CENTER_Y       = 3'd4,
    CFG_DEPTH_MIN      = 3'd5,
    CFG_DEPTH_MAX      = 3'd6,
    CFG_STOP_DIST      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STEER_STRAIGHT = 2'd0,
    STEER_LEFT     = 2'd1,
    STEER_RIGHT    = 2'd2
  } steer_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIV, OP_DEPTH, OP_MUL_XN, OP_XINIT, OP_XDONE,
    OP_YINIT, OP_YDONE, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_SQ1, OP_SQ2,
    OP_SQ3, OP_CINIT, OP_ISQ, OP_RND, OP_CORD, OP_ANG, OP_UPD, OP_SCAN_INIT,
    OP_SCAN_RD, OP_SCAN_CMP, OP_POST_F, OP_RD_REQ, OP_POST_R
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic kind_read;
    logic last;
    logic depth_bad;
    logic pt_bad;
    logic sq_bad;
    logic ang_bad;
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

// File: sv/dlsp_ram.sv
// ----------------------------------------------------------------------------
// dlsp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dlsp_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 241
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sv/dlsp_ctrl.sv
// ----------------------------------------------------------------------------
// dlsp_ctrl
// Sequencer: steps the datapath through one pixel, bin read or frame end.
// ----------------------------------------------------------------------------
module dlsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dlsp_pkg::sts_t sts_i,
  output dlsp_pkg::cmd_t cmd_o
);

  typedef enum logic [29:0] {
    ST_IDLE     = 30'b1 << 0,
    ST_DIV_D    = 30'b1 << 1,
    ST_DEPTH    = 30'b1 << 2,
    ST_CHK_D    = 30'b1 << 3,
    ST_XINIT    = 30'b1 << 4,
    ST_DIV_X    = 30'b1 << 5,
    ST_XDONE    = 30'b1 << 6,
    ST_YINIT    = 30'b1 << 7,
    ST_DIV_Y    = 30'b1 << 8,
    ST_YDONE    = 30'b1 << 9,
    ST_M1       = 30'b1 << 10,
    ST_M2       = 30'b1 << 11,
    ST_M3       = 30'b1 << 12,
    ST_M4       = 30'b1 << 13,
    ST_M5       = 30'b1 << 14,
    ST_CHK_BZ   = 30'b1 << 15,
    ST_SQ2      = 30'b1 << 16,
    ST_SQ3      = 30'b1 << 17,
    ST_CHK_SQ   = 30'b1 << 18,
    ST_ISQ      = 30'b1 << 19,
    ST_RND      = 30'b1 << 20,
    ST_CORD     = 30'b1 << 21,
    ST_ANG      = 30'b1 << 22,
    ST_UPD      = 30'b1 << 23,
    ST_FRAME    = 30'b1 << 24,
    ST_SCAN_RD  = 30'b1 << 25,
    ST_SCAN_CMP = 30'b1 << 26,
    ST_POST_F   = 30'b1 << 27,
    ST_RD_REQ   = 30'b1 << 28,
    ST_POST_R   = 30'b1 << 29
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = 5'd0;
    in_ready_o = 1'b0;
    cmd_o.op   = dlsp_pkg::OP_NONE;
    cmd_o.step = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = dlsp_pkg::OP_LOAD;
          state_d  = sts_i.kind_read ? ST_RD_REQ : ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        cmd_o.op = dlsp_pkg::OP_DIV;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == dlsp_pkg::DIV_LAST) begin
          state_d = ST_DEPTH;
        end
      end
      ST_DEPTH: begin
        cmd_o.op = dlsp_pkg::OP_DEPTH;
        state_d  = ST_CHK_D;
      end
      ST_CHK_D: begin
        cmd_o.op = dlsp_pkg::OP_MUL_XN;
        state_d  = sts_i.depth_bad ? ST_FRAME : ST_XINIT;
      end
      ST_XINIT: begin
        cmd_o.op = dlsp_pkg::OP_XINIT;
        state_d  = ST_DIV_X;
      end
      ST_DIV_X: begin
        cmd_o.op = dlsp_pkg::OP_DIV;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == dlsp_pkg::DIV_LAST) begin
          state_d = ST_XDONE;
        end
      end
      ST_XDONE: begin
        cmd_o.op = dlsp_pkg::OP_XDONE;
        state_d  = ST_YINIT;
      end
      ST_YINIT: begin
        cmd_o.op = dlsp_pkg::OP_YINIT;
        state_d  = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        cmd_o.op = dlsp_pkg::OP_DIV;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == dlsp_pkg::DIV_LAST) begin
          state_d = ST_YDONE;
        end
      end
      ST_YDONE: begin
        cmd_o.op = dlsp_pkg::OP_YDONE;
        state_d  = ST_M1;
      end
      ST_M1: begin
        cmd_o.op = dlsp_pkg::OP_M1;
        state_d  = ST_M2;
      end
      ST_M2: begin
        cmd_o.op = dlsp_pkg::OP_M2;
        state_d  = ST_M3;
      end
      ST_M3: begin
        cmd_o.op = dlsp_pkg::OP_M3;
        state_d  = ST_M4;
      end
      ST_M4: begin
        cmd_o.op = dlsp_pkg::OP_M4;
        state_d  = ST_M5;
      end
      ST_M5: begin
        cmd_o.op = dlsp_pkg::OP_M5;
        state_d  = ST_CHK_BZ;
      end
      ST_CHK_BZ: begin
        cmd_o.op = dlsp_pkg::OP_SQ1;
        state_d  = sts_i.pt_bad ? ST_FRAME : ST_SQ2;
      end
      ST_SQ2: begin
        cmd_o.op = dlsp_pkg::OP_SQ2;
        state_d  = ST_SQ3;
      end
      ST_SQ3: begin
        cmd_o.op = dlsp_pkg::OP_SQ3;
        state_d  = ST_CHK_SQ;
      end
      ST_CHK_SQ: begin
        cmd_o.op = dlsp_pkg::OP_CINIT;
        state_d  = sts_i.sq_bad ? ST_FRAME : ST_ISQ;
      end
      ST_ISQ: begin
        cmd_o.op = dlsp_pkg::OP_ISQ;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == dlsp_pkg::ISQ_LAST) begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        cmd_o.op = dlsp_pkg::OP_RND;
        state_d  = ST_CORD;
      end
      ST_CORD: begin
        cmd_o.op = dlsp_pkg::OP_CORD;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == dlsp_pkg::CORD_LAST) begin
          state_d = ST_ANG;
        end
      end
      ST_ANG: begin
        cmd_o.op = dlsp_pkg::OP_ANG;
        state_d  = sts_i.ang_bad ? ST_FRAME : ST_UPD;
      end
      ST_UPD: begin
        cmd_o.op = dlsp_pkg::OP_UPD;
        state_d  = ST_FRAME;
      end
      ST_FRAME: begin
        if (sts_i.last) begin
          cmd_o.op = dlsp_pkg::OP_SCAN_INIT;
          state_d  = ST_SCAN_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        cmd_o.op = dlsp_pkg::OP_SCAN_RD;
        state_d  = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd_o.op = dlsp_pkg::OP_SCAN_CMP;
        state_d  = sts_i.scan_done ? ST_POST_F : ST_SCAN_RD;
      end
      ST_POST_F: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = dlsp_pkg::OP_POST_F;
          state_d  = ST_IDLE;
        end
      end
      ST_RD_REQ: begin
        cmd_o.op = dlsp_pkg::OP_RD_REQ;
        state_d  = ST_POST_R;
      end
      ST_POST_R: begin
        if (sts_i.out_busy) begin
          cmd_o.op = dlsp_pkg::OP_RD_REQ;
        end else begin
          cmd_o.op = dlsp_pkg::OP_POST_R;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: sv/dlsp_dp.sv
// ----------------------------------------------------------------------------
// dlsp_dp
// Datapath: config registers, serial divider, shared multiplier, square
// root, CORDIC, bin memory with valid bits, nearest scan and result register.
// ----------------------------------------------------------------------------
module dlsp_dp #(
  parameter int unsigned NUM_BINS = 241
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dlsp_pkg::cmd_t                      cmd_i,
  output dlsp_pkg::sts_t                      sts_o,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_addr_i,
  input  logic [23:0]                         cfg_data_i,
  input  logic [dlsp_pkg::IN_TDATA_W-1:0]     in_tdata_i,
  input  logic                                in_tuser_i,
  input  logic                                in_tlast_i,
  input  logic                                out_tready_i,
  output logic                                out_tvalid_o,
  output logic [dlsp_pkg::OUT_TDATA_W-1:0]    out_tdata_o,
  output logic                                out_tuser_o
);

  localparam int unsigned AW = $clog2(NUM_BINS);
  localparam int unsigned H  = (NUM_BINS - 1) / 2;
  localparam logic signed [31:0] ANG_LO = 32'(-(int'(H) * 65536));
  localparam logic signed [31:0] ANG_HI = 32'(int'(NUM_BINS - 1 - H) * 65536);
  localparam logic [AW-1:0] BIN_LAST = AW'(NUM_BINS - 1);

  // configuration
  logic [23:0] fb_q;
  logic [11:0] fx_q, fy_q;
  logic [14:0] cx_q, cy_q;
  logic [15:0] dmin_q, dmax_q;
  logic [16:0] stop_q;

  // item
  logic [9:0]  row_q, disp_q;
  logic [10:0] col_q;
  logic [7:0]  idx_q;
  logic        last_q;

  // divider
  logic [31:0] num_q;
  logic [15:0] den_q, rem_q;
  logic        neg_q;
  logic [16:0] div_t, div_sub;
  logic        div_ge;

  // arithmetic
  logic [15:0]        depth_q;
  logic signed [29:0] xv_q, yv_q, bx_q, by_q, bz_q;
  logic signed [29:0] mul_a, quo_s;
  logic signed [17:0] mul_b;
  logic signed [47:0] prod_q, acc_q, prod_c, mag;
  logic signed [16:0] dcol, drow;
  logic [11:0]        fx_eff, fy_eff;
  logic [15:0]        den_x, den_y;
  logic [35:0]        n_q, r_q, bit_q, rb;
  logic [16:0]        rng_q;

  // cordic
  logic signed [37:0] cxv_q, cyv_q, x0, y0, dxs, dys;
  logic signed [25:0] z_q, z_eff;
  logic               zero_q;
  logic signed [31:0] zx, zdiff;
  logic [AW-1:0]      bin_c, bin_q;
  logic               ang_bad;

  // bins
  logic [NUM_BINS-1:0] valid_q;
  logic                clear_q, vld_rd_q;
  logic [AW-1:0]       raddr, k_q, nb_q, idx_addr;
  logic [16:0]         rdata, bin_val, nr_q;
  logic                nv_q, ram_we, idx_ok;

  // result
  logic        ov_q, orkind_q, oobst_q;
  logic [16:0] obin_q, onear_q;
  logic [7:0]  oang_q;
  logic [1:0]  osteer_q;
  logic [15:0] ang16;

  function automatic logic signed [29:0] q15(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd16384;
    return t[44:15];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q   <= 24'd84000;
      fx_q   <= 12'd700;
      fy_q   <= 12'd700;
      cx_q   <= 15'd10240;
      cy_q   <= 15'd5760;
      dmin_q <= 16'd300;
      dmax_q <= 16'd10000;
      stop_q <= 17'd500;
    end else if (cfg_we_i) begin
      unique case (dlsp_pkg::cfg_idx_e'(cfg_addr_i))
        dlsp_pkg::CFG_FOCAL_BASELINE: fb_q   <= cfg_data_i;
        dlsp_pkg::CFG_FOCAL_X:        fx_q   <= cfg_data_i[11:0];
        dlsp_pkg::CFG_FOCAL_Y:        fy_q   <= cfg_data_i[11:0];
        dlsp_pkg::CFG_CENTER_X:       cx_q   <= cfg_data_i[14:0];
        dlsp_pkg::CFG_CENTER_Y:       cy_q   <= cfg_data_i[14:0];
        dlsp_pkg::CFG_DEPTH_MIN:      dmin_q <= cfg_data_i[15:0];
        dlsp_pkg::CFG_DEPTH_MAX:      dmax_q <= cfg_data_i[15:0];
        dlsp_pkg::CFG_STOP_DIST:      stop_q <= cfg_data_i[16:0];
      endcase
    end
  end

  assign fx_eff  = (fx_q == 12'd0) ? 12'd1 : fx_q;
  assign fy_eff  = (fy_q == 12'd0) ? 12'd1 : fy_q;
  assign den_x   = {fx_eff, 4'b0};
  assign den_y   = {fy_eff, 4'b0};
  assign dcol    = $signed({2'b0, col_q, 4'b0}) - $signed({2'b0, cx_q});
  assign drow    = $signed({3'b0, row_q, 4'b0}) - $signed({2'b0, cy_q});
  assign mag     = prod_q[47] ? -prod_q : prod_q;
  assign quo_s   = neg_q ? -$signed({2'b0, num_q[27:0]}) : $signed({2'b0, num_q[27:0]});
  assign div_t   = {rem_q, num_q[31]};
  assign div_ge  = div_t >= {1'b0, den_q};
  assign div_sub = div_t - {1'b0, den_q};
  assign rb      = r_q + bit_q;

  always_comb begin
    mul_a = {14'b0, depth_q};
    mul_b = dlsp_pkg::PITCH_C;
    unique case (cmd_i.op)
      dlsp_pkg::OP_MUL_XN: begin
        mul_a = {{13{dcol[16]}}, dcol};
        mul_b = {2'b0, depth_q};
      end
      dlsp_pkg::OP_XDONE: begin
        mul_a = {{13{drow[16]}}, drow};
        mul_b = {2'b0, depth_q};
      end
      dlsp_pkg::OP_M2: begin
        mul_a = yv_q;
        mul_b = dlsp_pkg::PITCH_S;
      end
      dlsp_pkg::OP_M3: begin
        mul_b = dlsp_pkg::PITCH_S;
      end
      dlsp_pkg::OP_M4: begin
        mul_a = yv_q;
      end
      dlsp_pkg::OP_SQ1: begin
        mul_a = bx_q;
        mul_b = bx_q[17:0];
      end
      dlsp_pkg::OP_SQ2: begin
        mul_a = by_q;
        mul_b = by_q[17:0];
      end
      default: ;
    endcase
    prod_c = 48'(mul_a) * 48'(mul_b);
  end

  // cordic start vectors and shift terms, angle to bin
  always_comb begin
    x0 = {{4{bx_q[17]}}, bx_q[17:0], 16'b0};
    y0 = {{4{by_q[17]}}, by_q[17:0], 16'b0};
    dxs = cyv_q >>> cmd_i.step[3:0];
    dys = cxv_q >>> cmd_i.step[3:0];
    z_eff = zero_q ? 26'sd0 : z_q;
    zx = {{6{z_eff[25]}}, z_eff};
    zdiff = zx - ANG_LO;
    ang_bad = (zx < ANG_LO) || (zx > ANG_HI);
    if (zdiff[31:16] > 16'(NUM_BINS - 1)) begin
      bin_c = BIN_LAST;
    end else begin
      bin_c = zdiff[16+AW-1:16];
    end
  end

  assign idx_addr = AW'(idx_q);
  assign idx_ok   = 32'(idx_q) < 32'(NUM_BINS);

  always_comb begin
    unique case (cmd_i.op)
      dlsp_pkg::OP_ANG:    raddr = bin_c;
      dlsp_pkg::OP_RD_REQ: raddr = idx_addr;
      default:             raddr = k_q;
    endcase
  end

  assign bin_val = vld_rd_q ? rdata : dlsp_pkg::FAR_RANGE;
  assign ram_we  = (cmd_i.op == dlsp_pkg::OP_UPD) && (rng_q < bin_val);

  dlsp_ram #(
    .WIDTH (17),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bin_q),
    .wdata_i (rng_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    vld_rd_q <= valid_q[raddr];
    unique case (cmd_i.op)
      dlsp_pkg::OP_LOAD: begin
        row_q  <= in_tdata_i[9:0];
        col_q  <= in_tdata_i[20:10];
        disp_q <= in_tdata_i[30:21];
        idx_q  <= in_tdata_i[38:31];
        last_q <= in_tlast_i;
        num_q  <= 32'(fb_q) + 32'(in_tdata_i[30:22]);
        den_q  <= {6'b0, in_tdata_i[30:21]};
        rem_q  <= 16'd0;
      end
      dlsp_pkg::OP_DIV: begin
        rem_q <= div_ge ? div_sub[15:0] : div_t[15:0];
        num_q <= {num_q[30:0], div_ge};
      end
      dlsp_pkg::OP_DEPTH: begin
        if (disp_q == 10'd0) begin
          depth_q <= 16'd0;
        end else if (|num_q[31:16]) begin
          depth_q <= 16'hFFFF;
        end else begin
          depth_q <= num_q[15:0];
        end
      end
      dlsp_pkg::OP_MUL_XN: prod_q <= prod_c;
      dlsp_pkg::OP_XINIT: begin
        num_q <= mag[31:0] + {17'b0, den_x[15:1]};
        den_q <= den_x;
        rem_q <= 16'd0;
        neg_q <= prod_q[47];
      end
      dlsp_pkg::OP_XDONE: begin
        xv_q   <= quo_s;
        prod_q <= prod_c;
      end
      dlsp_pkg::OP_YINIT: begin
        num_q <= mag[31:0] + {17'b0, den_y[15:1]};
        den_q <= den_y;
        rem_q <= 16'd0;
        neg_q <= prod_q[47];
      end
      dlsp_pkg::OP_YDONE: yv_q <= quo_s;
      dlsp_pkg::OP_M1:    prod_q <= prod_c;
      dlsp_pkg::OP_M2: begin
        acc_q  <= prod_q;
        prod_q <= prod_c;
      end
      dlsp_pkg::OP_M3: begin
        bx_q   <= q15(acc_q - prod_q);
        prod_q <= prod_c;
      end
      dlsp_pkg::OP_M4: begin
        acc_q  <= -prod_q;
        prod_q <= prod_c;
      end
      dlsp_pkg::OP_M5: begin
        bz_q <= q15(acc_q - prod_q);
        by_q <= -xv_q;
      end
      dlsp_pkg::OP_SQ1: prod_q <= prod_c;
      dlsp_pkg::OP_SQ2: begin
        acc_q  <= prod_q;
        prod_q <= prod_c;
      end
      dlsp_pkg::OP_SQ3: n_q <= 36'(acc_q + prod_q);
      dlsp_pkg::OP_CINIT: begin
        r_q    <= 36'd0;
        bit_q  <= 36'd1 << 34;
        zero_q <= (bx_q == 30'sd0) && (by_q == 30'sd0);
        if (x0 < 0) begin
          if (y0 >= 0) begin
            cxv_q <= y0;
            cyv_q <= -x0;
            z_q   <= dlsp_pkg::Z_90;
          end else begin
            cxv_q <= -y0;
            cyv_q <= x0;
            z_q   <= -dlsp_pkg::Z_90;
          end
        end else begin
          cxv_q <= x0;
          cyv_q <= y0;
          z_q   <= 26'sd0;
        end
      end
      dlsp_pkg::OP_ISQ: begin
        if (n_q >= rb) begin
          n_q <= n_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      dlsp_pkg::OP_RND: rng_q <= (n_q > r_q) ? r_q[16:0] + 17'd1 : r_q[16:0];
      dlsp_pkg::OP_CORD: begin
        if (cyv_q >= 0) begin
          cxv_q <= cxv_q + dxs;
          cyv_q <= cyv_q - dys;
          z_q   <= z_q + $signed({4'b0, dlsp_pkg::ATAN_TAB[cmd_i.step[3:0]]});
        end else begin
          cxv_q <= cxv_q - dxs;
          cyv_q <= cyv_q + dys;
          z_q   <= z_q - $signed({4'b0, dlsp_pkg::ATAN_TAB[cmd_i.step[3:0]]});
        end
      end
      dlsp_pkg::OP_ANG: bin_q <= bin_c;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      clear_q <= 1'b0;
      nr_q    <= dlsp_pkg::FAR_RANGE;
      nb_q    <= '0;
      nv_q    <= 1'b0;
      k_q     <= '0;
    end else begin
      unique case (cmd_i.op)
        dlsp_pkg::OP_LOAD: begin
          if (in_tuser_i == dlsp_pkg::KIND_PIXEL && clear_q) begin
            valid_q <= '0;
            clear_q <= 1'b0;
          end
        end
        dlsp_pkg::OP_UPD: begin
          if (ram_we) begin
            valid_q[bin_q] <= 1'b1;
          end
        end
        dlsp_pkg::OP_SCAN_INIT: begin
          nr_q <= dlsp_pkg::FAR_RANGE;
          nb_q <= '0;
          nv_q <= 1'b0;
          k_q  <= '0;
        end
        dlsp_pkg::OP_SCAN_CMP: begin
          if (bin_val != 17'd0 && bin_val < nr_q) begin
            nr_q <= bin_val;
            nb_q <= k_q;
            nv_q <= 1'b1;
          end
          k_q <= k_q + 1'b1;
        end
        dlsp_pkg::OP_POST_F: clear_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign ang16 = 16'(nb_q) - 16'(H);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.op == dlsp_pkg::OP_POST_F || cmd_i.op == dlsp_pkg::OP_POST_R) begin
      ov_q <= 1'b1;
    end else if (out_tready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dlsp_pkg::OP_POST_F) begin
      orkind_q <= dlsp_pkg::RK_FRAME;
      obin_q   <= 17'd0;
      oobst_q  <= nv_q;
      onear_q  <= nr_q;
      oang_q   <= ang16[7:0];
      if (nv_q && nr_q <= stop_q) begin
        osteer_q <= (16'(nb_q) < 16'(H)) ? dlsp_pkg::STEER_LEFT : dlsp_pkg::STEER_RIGHT;
      end else begin
        osteer_q <= dlsp_pkg::STEER_STRAIGHT;
      end
    end else if (cmd_i.op == dlsp_pkg::OP_POST_R) begin
      orkind_q <= dlsp_pkg::RK_BIN;
      obin_q   <= idx_ok ? bin_val : 17'd0;
      oobst_q  <= 1'b0;
      onear_q  <= 17'd0;
      oang_q   <= 8'd0;
      osteer_q <= dlsp_pkg::STEER_STRAIGHT;
    end
  end

  assign out_tvalid_o = ov_q;
  assign out_tuser_o  = orkind_q;
  assign out_tdata_o  = {3'b0, osteer_q, oang_q, onear_q, oobst_q, obin_q};

  assign sts_o.kind_read = in_tuser_i == dlsp_pkg::KIND_READ;
  assign sts_o.last      = last_q;
  assign sts_o.depth_bad = !(depth_q > dmin_q && depth_q < dmax_q);
  assign sts_o.pt_bad    = bz_q > 30'sd10000 || bz_q < -30'sd100 ||
                           bx_q > 30'sd100000 || bx_q < -30'sd100000 ||
                           by_q > 30'sd100000 || by_q < -30'sd100000;
  assign sts_o.sq_bad    = n_q > dlsp_pkg::SQ_MAX;
  assign sts_o.ang_bad   = ang_bad;
  assign sts_o.scan_done = k_q == BIN_LAST;
  assign sts_o.out_busy  = ov_q && !out_tready_i;

endmodule

// File: sv/depth_to_laser_scan_projector_top.sv
// ----------------------------------------------------------------------------
// depth_to_laser_scan_projector_top
// Projects disparity pixels into a minimum-range laser scan, reports nearest.
// ----------------------------------------------------------------------------
// A rejected pixel leaves the sequence early; in a kept pixel the three 32-step
// divisions of the serial divider dominate, then square root and CORDIC.
// A frame-end pixel then scans the bin memory. One item is in work at a time.
// Reset restores register defaults and marks all bins empty via valid bits.
module depth_to_laser_scan_projector_top #(
  parameter int unsigned NUM_BINS = 241
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row[9:0], column[20:10], disparity[30:21], bin_index[38:31]
  input  logic [39:0] s_axis_tdata,
  // kind[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bin_range_mm[16:0], obstacle_found[17], nearest_range_mm[34:18],
  // nearest_angle_deg[42:35], steer[44:43]
  output logic [47:0] m_axis_tdata,
  // result_kind[0]
  output logic        m_axis_tuser
);

  dlsp_pkg::cmd_t cmd;
  dlsp_pkg::sts_t sts;

  dlsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlsp_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .in_tlast_i   (s_axis_tlast),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata),
    .out_tuser_o  (m_axis_tuser)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while busy");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == dlsp_pkg::RK_BIN) |-> m_axis_tdata[44:17] == 28'd0)
    else $error("bin read carries frame fields");

  a_steer_obst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[44:43] != dlsp_pkg::STEER_STRAIGHT) |-> m_axis_tdata[17])
    else $error("turn without obstacle");

  a_no_obst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == dlsp_pkg::RK_FRAME && !m_axis_tdata[17])
      |-> m_axis_tdata[34:18] == dlsp_pkg::FAR_RANGE)
    else $error("empty scan with nearest range");

endmodule
